// ===== hdl/fkp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fkp_pkg
// types and constants of the forward kinematics pose block
// ----------------------------------------------------------------------------
package fkp_pkg;

  localparam int FKP_SLOT_COUNT = 64;

  // one joint request
  typedef struct packed {
    logic        [5:0]  parent_slot;
    logic signed [31:0] local_x;
    logic signed [31:0] local_y;
    logic signed [31:0] local_z;
    logic signed [15:0] local_qx;
    logic signed [15:0] local_qy;
    logic signed [15:0] local_qz;
    logic signed [15:0] local_qw;
  } fkp_in_req_t;

  // one world pose result
  typedef struct packed {
    logic signed [31:0] world_x;
    logic signed [31:0] world_y;
    logic signed [31:0] world_z;
    logic signed [15:0] world_qx;
    logic signed [15:0] world_qy;
    logic signed [15:0] world_qz;
    logic signed [15:0] world_qw;
    logic               frame_end;
  } fkp_out_req_t;

  // stored pose of one slot
  typedef struct packed {
    logic [2:0][31:0] pos;
    logic [3:0][15:0] rot;
  } fkp_pose_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MOD,
    S_READ,
    S_LOAD,
    S_MAT,
    S_POS,
    S_SQ,
    S_SQRT,
    S_DIV,
    S_PROD,
    S_DONE
  } fkp_state_t;

endpackage
`default_nettype wire

// ===== hdl/forward_kinematics_pose.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// forward_kinematics_pose
// world pose of one joint from its parent slot and local pose, one shared
// multiplier with bit-serial square root and division under a sequencer
// ----------------------------------------------------------------------------
//  channel  direction  handshake                    payload
//  in_      request    in_valid / in_stall          fkp_in_req_t (one joint)
//  out_     result     out_valid / out_stall        fkp_out_req_t (world pose)
//  cfg_     write      cfg_wr_en                    cfg_wr_data = bone_count
//
//  one joint runs through these steps in order: fetch of the parent slot,
//  rotation matrix, position, normalisation of the local rotation, product
//  with the parent rotation, normalisation of that product, hand-over; each
//  normalisation is 32 square root iterations, then 16 division steps per
//  component; a parent beyond the store is wrapped by subtracting the slot
//  count; a zero quaternion skips root and division of its normalisation
//  a new request is taken only in idle; a finished result waits in the
//  output register and does not hold up the next request
//  reset clears the slot valid bits, so every slot reads as the identity
//  pose until written; no clearing pass is needed
//  out_stall delays the hand-over; a result still waiting at the end of the
//  next joint holds the block in the hand-over state
// ----------------------------------------------------------------------------
module forward_kinematics_pose
  import fkp_pkg::*;
#(
  parameter int SLOT_COUNT = FKP_SLOT_COUNT
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_valid,
  output      logic         in_stall,
  input  wire fkp_in_req_t  in_data,
  output      logic         out_valid,
  input  wire logic         out_stall,
  output      fkp_out_req_t out_data,
  input  wire logic         cfg_wr_en,
  input  wire logic [5:0]   cfg_wr_data
);

  localparam int AW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam logic [8:0] SLOT_W = 9'(SLOT_COUNT);
  localparam logic signed [67:0] ONE_Q28 = 68'sd268435456;
  localparam logic signed [67:0] MAT_LIM = 68'sd1073741824;
  localparam logic signed [67:0] I32_MAX = 68'sd2147483647;
  localparam logic signed [67:0] I32_MIN = -68'sd2147483648;
  localparam logic [15:0] ONE_Q14 = 16'd16384;

  // operand table of the rotation matrix: {a index, b index, subtract}
  function automatic logic [4:0] mat_op(input logic [3:0] g, input logic t);
    logic [4:0] r;
    begin
      r = '0;
      case (g)
        4'd0:    r = t ? 5'b10_10_1 : 5'b01_01_1;
        4'd1:    r = t ? 5'b11_10_1 : 5'b00_01_0;
        4'd2:    r = t ? 5'b11_01_0 : 5'b00_10_0;
        4'd3:    r = t ? 5'b11_10_0 : 5'b00_01_0;
        4'd4:    r = t ? 5'b10_10_1 : 5'b00_00_1;
        4'd5:    r = t ? 5'b11_00_1 : 5'b01_10_0;
        4'd6:    r = t ? 5'b11_01_1 : 5'b00_10_0;
        4'd7:    r = t ? 5'b11_00_0 : 5'b01_10_0;
        default: r = t ? 5'b01_01_1 : 5'b00_00_1;
      endcase
      return r;
    end
  endfunction

  // operand table of the hamilton product: {parent index, local index, subtract}
  function automatic logic [4:0] prod_op(input logic [1:0] g, input logic [1:0] t);
    logic [4:0] r;
    begin
      r = '0;
      case ({g, t})
        4'h0: r = 5'b11_00_0;
        4'h1: r = 5'b00_11_0;
        4'h2: r = 5'b01_10_0;
        4'h3: r = 5'b10_01_1;
        4'h4: r = 5'b11_01_0;
        4'h5: r = 5'b01_11_0;
        4'h6: r = 5'b10_00_0;
        4'h7: r = 5'b00_10_1;
        4'h8: r = 5'b11_10_0;
        4'h9: r = 5'b10_11_0;
        4'ha: r = 5'b00_01_0;
        4'hb: r = 5'b01_00_1;
        4'hc: r = 5'b11_11_0;
        4'hd: r = 5'b00_00_1;
        4'he: r = 5'b01_01_1;
        default: r = 5'b10_10_1;
      endcase
      return r;
    end
  endfunction

  // shift right with rounding to nearest, ties away from zero
  function automatic logic signed [67:0] rnd_shift(input logic signed [67:0] v,
                                                   input logic [4:0] sh);
    logic [67:0] mag;
    begin
      mag = v[67] ? unsigned'(-v) : unsigned'(v);
      mag = (mag + (68'd1 << (sh - 5'd1))) >> sh;
      return v[67] ? -signed'(mag) : signed'(mag);
    end
  endfunction

  // state and control
  fkp_state_t state_r, state_nxt;
  logic [2:0] t_r, t_nxt;
  logic [3:0] g_r, g_nxt;
  logic       phase_r;
  logic [5:0] src_r;
  fkp_in_req_t req_r;

  // slot store
  fkp_pose_t       slot_mem [SLOT_COUNT];
  logic [SLOT_COUNT-1:0] slot_vld_r;
  fkp_pose_t       rd_pose_r;
  logic            rd_vld_r;
  logic [8:0]      src_ext, dst_full;
  logic [AW-1:0]   src_idx, dst_idx;

  // datapath
  logic [3:0][15:0] pq_r, n_r, wq_r;
  logic [2:0][31:0] pp_r, wp_r, v_vec;
  logic [8:0][31:0] m_r;
  logic [3:0][25:0] c_r;
  logic signed [67:0] acc_r;
  logic signed [63:0] mul_r;
  logic        mneg_r, mvld_r;
  logic [50:0] s_r;
  logic [63:0] sq_v_r, sq_q_r, sq_bit_r;
  logic [4:0]  sq_cnt_r;
  logic [31:0] len_r;
  logic [47:0] rem_r, dv_r;
  logic [15:0] quo_r;
  logic [3:0]  dstep_r;
  logic [1:0]  dcomp_r;

  // output and counters
  logic         out_valid_r;
  fkp_out_req_t out_data_r;
  logic [5:0]   bone_count_r, joint_cnt_r;

  // shared multiplier operands
  logic signed [31:0] mul_a, mul_b;
  logic        mac_neg, mac_state, issue, consume, last_group;
  logic [2:0]  n_terms;
  logic [3:0]  n_groups;
  logic signed [67:0] acc_init;
  logic [4:0]  op;
  logic [3:0]  m_idx;

  assign v_vec    = {req_r.local_z, req_r.local_y, req_r.local_x};
  assign src_ext  = 9'(src_r);
  assign src_idx  = src_ext[AW-1:0];
  assign dst_full = 9'(req_r.parent_slot) + 9'd1;
  assign dst_idx  = dst_full[AW-1:0];
  assign m_idx    = 4'({g_r, 1'b0} + g_r + 4'(t_r));

  always_comb begin
    state_nxt  = state_r;
    t_nxt      = t_r;
    g_nxt      = g_r;
    n_terms    = '0;
    n_groups   = 4'd1;
    mul_a      = '0;
    mul_b      = '0;
    mac_neg    = 1'b0;
    acc_init   = '0;
    op         = '0;
    mac_state  = 1'b0;
    unique case (state_r)
      S_MAT: begin
        mac_state = 1'b1;
        n_terms   = 3'd2;
        n_groups  = 4'd9;
        op        = mat_op(g_r, t_r[0]);
        mul_a     = {{15{pq_r[op[4:3]][15]}}, pq_r[op[4:3]], 1'b0};
        mul_b     = {{16{pq_r[op[2:1]][15]}}, pq_r[op[2:1]]};
        mac_neg   = op[0];
        if (g_r == 4'd0 || g_r == 4'd4 || g_r == 4'd8) acc_init = ONE_Q28;
      end
      S_POS: begin
        mac_state = 1'b1;
        n_terms   = 3'd3;
        n_groups  = 4'd3;
        mul_a     = signed'(m_r[m_idx]);
        mul_b     = signed'(v_vec[t_r[1:0]]);
      end
      S_SQ: begin
        mac_state = 1'b1;
        n_terms   = 3'd4;
        mul_a     = {{6{c_r[t_r[1:0]][25]}}, c_r[t_r[1:0]]};
        mul_b     = mul_a;
      end
      S_PROD: begin
        mac_state = 1'b1;
        n_terms   = 3'd4;
        n_groups  = 4'd4;
        op        = prod_op(g_r[1:0], t_r[1:0]);
        mul_a     = {{16{pq_r[op[4:3]][15]}}, pq_r[op[4:3]]};
        mul_b     = {{16{n_r[op[2:1]][15]}}, n_r[op[2:1]]};
        mac_neg   = op[0];
      end
      default: ;
    endcase

    issue      = mac_state && (t_r < n_terms);
    consume    = mac_state && (t_r == n_terms + 3'd1);
    last_group = (g_r == n_groups - 4'd1);

    if (mac_state) begin
      if (consume) begin
        t_nxt = '0;
        g_nxt = last_group ? 4'd0 : g_r + 4'd1;
      end else begin
        t_nxt = t_r + 3'd1;
      end
    end

    unique case (state_r)
      S_IDLE: if (in_valid) state_nxt = S_MOD;
      S_MOD:  if (src_ext < SLOT_W) state_nxt = S_READ;
      S_READ: state_nxt = S_LOAD;
      S_LOAD: state_nxt = S_MAT;
      S_MAT:  if (consume && last_group) state_nxt = S_POS;
      S_POS:  if (consume && last_group) state_nxt = S_SQ;
      S_SQ: begin
        if (consume) begin
          if (acc_r != '0)  state_nxt = S_SQRT;
          else if (phase_r) state_nxt = S_DONE;
          else              state_nxt = S_PROD;
        end
      end
      S_SQRT: if (sq_cnt_r == 5'd31) state_nxt = S_DIV;
      S_DIV: begin
        if (dstep_r == 4'd15 && dcomp_r == 2'd3) state_nxt = phase_r ? S_DONE : S_PROD;
      end
      S_PROD: if (consume && last_group) state_nxt = S_SQ;
      S_DONE: if (!out_valid_r || !out_stall) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      t_r     <= '0;
      g_r     <= '0;
    end else begin
      state_r <= state_nxt;
      t_r     <= t_nxt;
      g_r     <= g_nxt;
    end
  end

  // square root iteration
  logic [63:0] sq_try, sq_q_next;
  logic        sq_ge;
  assign sq_try    = sq_q_r + sq_bit_r;
  assign sq_ge     = sq_v_r >= sq_try;
  assign sq_q_next = sq_ge ? (sq_q_r >> 1) + sq_bit_r : sq_q_r >> 1;

  // division step and start of the next component
  logic [15:0] quo_next, q_res;
  logic        dv_ge, c_neg;
  logic [1:0]  div_k;
  logic [31:0] div_len;
  logic [25:0] div_mag;
  logic [47:0] rem_init;
  assign dv_ge    = rem_r >= dv_r;
  assign quo_next = {quo_r[14:0], dv_ge};
  assign div_k    = (state_r == S_SQRT) ? 2'd0 : dcomp_r + 2'd1;
  assign div_len  = (state_r == S_SQRT) ? sq_q_next[31:0] : len_r;
  assign div_mag  = c_r[div_k][25] ? 26'(-c_r[div_k]) : c_r[div_k];
  assign rem_init = {2'b00, div_mag, 20'b0} + {17'b0, div_len[31:1]};
  assign c_neg    = c_r[dcomp_r][25];
  always_comb begin
    if (c_neg) q_res = (quo_next > 16'd32768) ? 16'h8000 : 16'(-quo_next);
    else       q_res = (quo_next > 16'd32767) ? 16'h7fff : quo_next;
  end

  // position row and quaternion product results
  logic signed [67:0] pos_sum, pos_rnd;
  logic signed [67:0] prod_rnd;
  assign pos_rnd  = rnd_shift(acc_r, 5'd28);
  assign pos_sum  = pos_rnd + {{36{pp_r[g_r[1:0]][31]}}, pp_r[g_r[1:0]]};
  assign prod_rnd = rnd_shift(acc_r, 5'd8);

  logic frame_end;
  assign frame_end = ({1'b0, joint_cnt_r} + 7'd1) >= {1'b0, bone_count_r};

  logic done_go;
  assign done_go = (state_r == S_DONE) && (!out_valid_r || !out_stall);

  // shared multiplier, registered before the accumulator
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mvld_r <= 1'b0;
    end else begin
      mvld_r <= issue;
    end
    mul_r  <= mul_a * mul_b;
    mneg_r <= mac_neg;
  end

  // datapath
  always_ff @(posedge clk) begin
    if (issue && t_r == 3'd0) begin
      acc_r <= acc_init;
    end else if (mvld_r) begin
      acc_r <= mneg_r ? acc_r - {{4{mul_r[63]}}, mul_r} : acc_r + {{4{mul_r[63]}}, mul_r};
    end

    case (state_r)
      S_IDLE: begin
        req_r <= in_data;
        src_r <= in_data.parent_slot;
      end
      S_MOD: if (src_ext >= SLOT_W) src_r <= src_r - SLOT_W[5:0];
      S_LOAD: begin
        phase_r <= 1'b0;
        pq_r    <= rd_vld_r ? rd_pose_r.rot : {ONE_Q14, 16'd0, 16'd0, 16'd0};
        pp_r    <= rd_vld_r ? rd_pose_r.pos : '0;
        c_r     <= {{{4{req_r.local_qw[15]}}, req_r.local_qw, 6'b0},
                    {{4{req_r.local_qz[15]}}, req_r.local_qz, 6'b0},
                    {{4{req_r.local_qy[15]}}, req_r.local_qy, 6'b0},
                    {{4{req_r.local_qx[15]}}, req_r.local_qx, 6'b0}};
      end
      S_MAT: begin
        if (consume) begin
          if (acc_r > MAT_LIM)       m_r[g_r] <= MAT_LIM[31:0];
          else if (acc_r < -MAT_LIM) m_r[g_r] <= 32'(-MAT_LIM);
          else                       m_r[g_r] <= acc_r[31:0];
        end
      end
      S_POS: begin
        if (consume) begin
          if (pos_sum > I32_MAX)      wp_r[g_r[1:0]] <= I32_MAX[31:0];
          else if (pos_sum < I32_MIN) wp_r[g_r[1:0]] <= I32_MIN[31:0];
          else                        wp_r[g_r[1:0]] <= pos_sum[31:0];
        end
      end
      S_SQ: begin
        if (consume) begin
          s_r      <= acc_r[50:0];
          sq_v_r   <= {1'b0, acc_r[50:0], 12'b0};
          sq_q_r   <= '0;
          sq_bit_r <= 64'h4000_0000_0000_0000;
          sq_cnt_r <= '0;
          // zero quaternion normalises to identity
          if (acc_r == '0) begin
            if (phase_r) wq_r <= {ONE_Q14, 16'd0, 16'd0, 16'd0};
            else         n_r  <= {ONE_Q14, 16'd0, 16'd0, 16'd0};
          end
        end
      end
      S_SQRT: begin
        if (sq_ge) sq_v_r <= sq_v_r - sq_try;
        sq_q_r   <= sq_q_next;
        sq_bit_r <= sq_bit_r >> 2;
        sq_cnt_r <= sq_cnt_r + 5'd1;
        if (sq_cnt_r == 5'd31) begin
          len_r   <= sq_q_next[31:0];
          rem_r   <= rem_init;
          dv_r    <= {1'b0, div_len, 15'b0};
          quo_r   <= '0;
          dstep_r <= '0;
          dcomp_r <= '0;
        end
      end
      S_DIV: begin
        if (dstep_r == 4'd15) begin
          if (phase_r) wq_r[dcomp_r] <= q_res;
          else         n_r[dcomp_r]  <= q_res;
          rem_r   <= rem_init;
          dv_r    <= {1'b0, div_len, 15'b0};
          quo_r   <= '0;
          dstep_r <= '0;
          dcomp_r <= dcomp_r + 2'd1;
        end else begin
          if (dv_ge) rem_r <= rem_r - dv_r;
          dv_r    <= dv_r >> 1;
          quo_r   <= quo_next;
          dstep_r <= dstep_r + 4'd1;
        end
      end
      S_PROD: begin
        if (consume) begin
          c_r[g_r[1:0]] <= prod_rnd[25:0];
          if (last_group) phase_r <= 1'b1;
        end
      end
      default: ;
    endcase
  end

  // slot store, registered read at the reduced parent slot
  always_ff @(posedge clk) begin
    rd_pose_r <= slot_mem[src_idx];
    if (done_go && dst_full < SLOT_W) slot_mem[dst_idx] <= {wp_r, wq_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_vld_r <= '0;
      rd_vld_r   <= 1'b0;
    end else begin
      rd_vld_r <= slot_vld_r[src_idx];
      if (done_go && dst_full < SLOT_W) slot_vld_r[dst_idx] <= 1'b1;
    end
  end

  // result register, frame counter and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      bone_count_r <= 6'd1;
      joint_cnt_r  <= '0;
    end else begin
      if (cfg_wr_en) bone_count_r <= cfg_wr_data;
      if (done_go) begin
        out_valid_r <= 1'b1;
        joint_cnt_r <= frame_end ? 6'd0 : joint_cnt_r + 6'd1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (done_go) begin
      out_data_r.world_x   <= wp_r[0];
      out_data_r.world_y   <= wp_r[1];
      out_data_r.world_z   <= wp_r[2];
      out_data_r.world_qx  <= wq_r[0];
      out_data_r.world_qy  <= wq_r[1];
      out_data_r.world_qz  <= wq_r[2];
      out_data_r.world_qw  <= wq_r[3];
      out_data_r.frame_end <= frame_end;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // a taken request keeps the block busy in the following cycle
  a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("request taken while the previous one is starting");

  // a result only appears after the hand-over state
  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE))
    else $error("result raised outside the hand-over state");

  // square root is only run on a non-zero sum of squares
  a_sqrt_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SQRT) |-> (s_r != '0))
    else $error("square root started on a zero quaternion");

endmodule
`default_nettype wire

// ===== tb/tb_forward_kinematics_pose.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_forward_kinematics_pose
// joint requests against a behavioural pose predictor: directed table of
// edge cases, then random skeleton chains with random idling on both sides
// ----------------------------------------------------------------------------
module tb_forward_kinematics_pose;
  import fkp_pkg::*;

  localparam int SLOTS = FKP_SLOT_COUNT;
  localparam int DRAIN_CYCLES = 400;
  localparam logic signed [15:0] Q_ONE = 16'sd16384;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_valid = 1'b0;
  logic         in_stall;
  fkp_in_req_t  in_data = '0;
  logic         out_valid;
  logic         out_stall = 1'b0;
  fkp_out_req_t out_data;
  logic         cfg_wr_en = 1'b0;
  logic [5:0]   cfg_wr_data = 6'd1;

  forward_kinematics_pose i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
  );

  always #4 clk = ~clk;

  // predictor state: world pose per slot, frame counter, bone count
  logic signed [31:0] pose_pos [SLOTS][3];
  logic signed [15:0] pose_rot [SLOTS][4];
  int unsigned        joint_idx;
  int unsigned        bones;

  fkp_out_req_t pending_poses[$];
  int           mismatches = 0;
  int           poses_seen = 0;
  int           requests_sent = 0;
  bit           idle_enable = 1'b1;

  function automatic longint rnd_shift(longint v, int sh);
    longint m;
    m = (v < 0) ? -v : v;
    m = (m + (longint'(1) <<< (sh - 1))) >>> sh;
    return (v < 0) ? -m : m;
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // unit quaternion in q2.14 from components in q.20
  function automatic void unit_quat(input longint c [4], output longint q [4]);
    longint unsigned sum, len, m;
    sum = 0;
    for (int i = 0; i < 4; i++) sum += longint'(c[i] * c[i]);
    if (sum == 0) begin
      q[0] = 0; q[1] = 0; q[2] = 0; q[3] = 16384;
    end else begin
      len = int_sqrt(sum << 12);
      for (int i = 0; i < 4; i++) begin
        m = (c[i] < 0) ? -c[i] : c[i];
        m = ((m << 20) + len / 2) / len;
        q[i] = clip((c[i] < 0) ? -longint'(m) : longint'(m), -32768, 32767);
      end
    end
  endfunction

  task automatic predictor_reset();
    for (int s = 0; s < SLOTS; s++) begin
      for (int i = 0; i < 3; i++) pose_pos[s][i] = '0;
      pose_rot[s][0] = '0; pose_rot[s][1] = '0; pose_rot[s][2] = '0;
      pose_rot[s][3] = Q_ONE;
    end
    joint_idx = 0;
    bones = 1;
  endtask

  function automatic fkp_out_req_t predict_pose(fkp_in_req_t r);
    fkp_out_req_t o;
    int src, dst;
    longint v[3], lq[4], nq[4], pr[4], wq[4], wp[3], m[3][3];
    longint px, py, pz, pw, acc;
    src = int'(r.parent_slot) % SLOTS;
    dst = int'(r.parent_slot) + 1;
    v[0] = r.local_x; v[1] = r.local_y; v[2] = r.local_z;
    lq[0] = longint'(r.local_qx) * 64; lq[1] = longint'(r.local_qy) * 64;
    lq[2] = longint'(r.local_qz) * 64; lq[3] = longint'(r.local_qw) * 64;
    px = pose_rot[src][0]; py = pose_rot[src][1];
    pz = pose_rot[src][2]; pw = pose_rot[src][3];
    m[0][0] = (64'sd1 <<< 28) - 2 * (py*py + pz*pz);
    m[0][1] = 2 * (px*py - pw*pz);
    m[0][2] = 2 * (px*pz + pw*py);
    m[1][0] = 2 * (px*py + pw*pz);
    m[1][1] = (64'sd1 <<< 28) - 2 * (px*px + pz*pz);
    m[1][2] = 2 * (py*pz - pw*px);
    m[2][0] = 2 * (px*pz - pw*py);
    m[2][1] = 2 * (py*pz + pw*px);
    m[2][2] = (64'sd1 <<< 28) - 2 * (px*px + py*py);
    for (int i = 0; i < 3; i++) begin
      acc = 0;
      for (int j = 0; j < 3; j++)
        acc += clip(m[i][j], -(64'sd1 <<< 30), 64'sd1 <<< 30) * v[j];
      acc = rnd_shift(acc, 28) + longint'(pose_pos[src][i]);
      wp[i] = clip(acc, -64'sd2147483648, 64'sd2147483647);
    end
    unit_quat(lq, nq);
    pr[0] = pw*nq[0] + px*nq[3] + py*nq[2] - pz*nq[1];
    pr[1] = pw*nq[1] + py*nq[3] + pz*nq[0] - px*nq[2];
    pr[2] = pw*nq[2] + pz*nq[3] + px*nq[1] - py*nq[0];
    pr[3] = pw*nq[3] - px*nq[0] - py*nq[1] - pz*nq[2];
    for (int i = 0; i < 4; i++) pr[i] = rnd_shift(pr[i], 8);
    unit_quat(pr, wq);
    if (dst < SLOTS) begin
      for (int i = 0; i < 3; i++) pose_pos[dst][i] = wp[i][31:0];
      for (int i = 0; i < 4; i++) pose_rot[dst][i] = wq[i][15:0];
    end
    o.world_x = wp[0][31:0]; o.world_y = wp[1][31:0]; o.world_z = wp[2][31:0];
    o.world_qx = wq[0][15:0]; o.world_qy = wq[1][15:0];
    o.world_qz = wq[2][15:0]; o.world_qw = wq[3][15:0];
    o.frame_end = (joint_idx + 1 >= bones);
    joint_idx = o.frame_end ? 0 : ((joint_idx + 1) & 32'h3f);
    return o;
  endfunction

  // result side: random stall bursts, compare against the oldest expectation
  always @(posedge clk) begin
    fkp_out_req_t want;
    if (rst_n && out_valid && !out_stall) begin
      poses_seen++;
      if (pending_poses.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected pose %h", out_data);
      end else begin
        want = pending_poses.pop_front();
        if (out_data !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("pose mismatch: exp %h got %h", want, out_data);
        end
      end
    end
  end

  initial begin
    int n;
    forever begin
      @(negedge clk);
      if (idle_enable && $urandom_range(0, 9) == 0) begin
        n = $urandom_range(1, 19);
        out_stall <= 1'b1;
        repeat (n) @(negedge clk);
      end
      out_stall <= 1'b0;
    end
  end

  // one joint request; the expected pose goes in the store on acceptance
  task automatic send_joint(input fkp_in_req_t r, input bit check_fixed,
                            input fkp_out_req_t fixed);
    fkp_out_req_t p;
    if (idle_enable && $urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 19)) @(negedge clk);
    end
    in_data  <= r;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    p = predict_pose(r);
    if (check_fixed && p !== fixed) begin
      mismatches++;
      if (mismatches <= 10) $display("table row disagrees: %h vs %h", fixed, p);
    end
    pending_poses.push_back(p);
    requests_sent++;
    @(negedge clk);
    in_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic drain();
    while (pending_poses.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic set_bones(input logic [5:0] b);
    drain();
    cfg_wr_data <= b;
    cfg_wr_en   <= 1'b1;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    bones = b;
  endtask

  function automatic logic signed [15:0] rnd_comp();
    case ($urandom_range(0, 5))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return 16'sh0000;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic logic signed [31:0] rnd_len();
    case ($urandom_range(0, 7))
      0: return 32'sh80000000;
      1: return 32'sh7fffffff;
      2: return $urandom;
      default: return 32'(int'($urandom_range(0, 20'hfffff)) - 20'h80000);
    endcase
  endfunction

  typedef struct {
    fkp_in_req_t  req;
    bit           fixed;
    fkp_out_req_t pose;
  } table_row_t;

  initial begin
    table_row_t   rows[$];
    table_row_t   row;
    fkp_in_req_t  r;
    int           depth;

    predictor_reset();
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // after reset: identity parent, unit local rotation, pose passes through
    row.req = '{6'd0, 32'sh00010000, -32'sh00020000, 32'sh00030000,
                16'sd0, 16'sd0, 16'sd0, Q_ONE};
    row.fixed = 1'b1;
    row.pose = '{32'sh00010000, -32'sh00020000, 32'sh00030000,
                 16'sd0, 16'sd0, 16'sd0, Q_ONE, 1'b1};
    rows.push_back(row);
    // zero local quaternion becomes identity
    row.req = '{6'd5, 32'sh7fffffff, 32'sh80000000, 32'sd0,
                16'sd0, 16'sd0, 16'sd0, 16'sd0};
    row.pose = '{32'sh7fffffff, 32'sh80000000, 32'sd0,
                 16'sd0, 16'sd0, 16'sd0, Q_ONE, 1'b1};
    rows.push_back(row);
    // last slot as parent: returned, never stored
    row.req = '{6'd63, 32'sd0, 32'sd0, 32'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0};
    row.pose = '{32'sd0, 32'sd0, 32'sd0, 16'sd0, 16'sd0, 16'sd0, Q_ONE, 1'b1};
    rows.push_back(row);
    row.req = '{6'd62, 32'sd0, 32'sd0, 32'sd0,
                16'sd0, 16'sd0, 16'sd0, 16'sh8000};
    row.fixed = 1'b0;
    rows.push_back(row);
    row.req = '{6'd63, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
                16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff};
    rows.push_back(row);
    // extreme quaternion components and saturating positions down a chain
    row.req = '{6'd0, 32'sh7fffffff, 32'sh7fffffff, 32'sh80000000,
                16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff};
    rows.push_back(row);
    row.req = '{6'd1, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff,
                16'sh7fff, 16'sd0, 16'sd0, 16'sd1};
    rows.push_back(row);
    row.req = '{6'd2, 32'sh80000000, 32'sh80000000, 32'sh80000000,
                16'sd1, 16'sd0, 16'sd0, 16'sd0};
    rows.push_back(row);
    row.req = '{6'd3, 32'sh00008000, 32'shffff8000, 32'sd1,
                16'sd0, 16'sd11585, 16'sd0, 16'sd11585};
    rows.push_back(row);
    row.req = '{6'd4, 32'shffffffff, 32'sd1, 32'sh00100000,
                16'shffff, 16'shffff, 16'shffff, 16'shffff};
    rows.push_back(row);
    row.req = '{6'd42, 32'sh12345678, 32'shedcba987, 32'sh0f0f0f0f,
                16'sh5555, 16'shaaaa, 16'sh3c3c, 16'shc3c3};
    rows.push_back(row);
    foreach (rows[k]) send_joint(rows[k].req, rows[k].fixed, rows[k].pose);

    // frame flag: bone count extremes, and lowering it mid frame
    set_bones(6'd63);
    repeat (5) begin
      r = '{6'($urandom_range(0, 62)), rnd_len(), rnd_len(), rnd_len(),
            rnd_comp(), rnd_comp(), rnd_comp(), rnd_comp()};
      send_joint(r, 1'b0, '0);
    end
    set_bones(6'd2);
    send_joint(r, 1'b0, '0);
    set_bones(6'd0);
    send_joint(r, 1'b0, '0);

    // random skeleton chains, with bone count changed between phases
    for (int phase = 0; phase < 6; phase++) begin
      set_bones(phase == 5 ? 6'd63 : 6'($urandom_range(1, 12)));
      if (phase == 5) idle_enable = 1'b0;
      for (int k = 0; k < 105; k++) begin
        if ($urandom_range(0, 4) == 0) begin
          r.parent_slot = 6'($urandom_range(0, 63));
        end else begin
          depth = (k == 0) ? 0 : (int'(r.parent_slot) + 1) % 63;
          r.parent_slot = 6'(depth);
        end
        r.local_x = rnd_len(); r.local_y = rnd_len(); r.local_z = rnd_len();
        r.local_qx = rnd_comp(); r.local_qy = rnd_comp();
        r.local_qz = rnd_comp(); r.local_qw = rnd_comp();
        send_joint(r, 1'b0, '0);
        // halfway through a phase, the sender holds off until all poses are back
        if (k == 50) while (pending_poses.size() != 0) @(negedge clk);
      end
    end

    drain();
    $display("%0d joint requests sent, %0d poses checked, %0d mismatches",
             requests_sent, poses_seen, mismatches);
    $display("covered chains, saturation, zero quaternions, last slot, frame ends");
    if (mismatches == 0 && pending_poses.size() == 0)
      $display("tb_forward_kinematics_pose passed");
    else
      $display("tb_forward_kinematics_pose failed");
    $finish;
  end

  // watchdog, several times the slowest expected run
  initial begin
    #40ms;
    $display("tb_forward_kinematics_pose failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/fkp_pkg.sv
hdl/forward_kinematics_pose.sv
tb/tb_forward_kinematics_pose.sv
